// ===== hw/rtl/bfdg_pkg.sv =====
// bfdg_pkg: shared types, constants and the 5-row font rom for the text dot generator
// no dependencies; used by every rtl file of the block
`default_nettype none

package bfdg_pkg;

  localparam int GLYPH_ROWS = 5;
  localparam int GLYPH_COLS = 5;
  localparam int CELLS      = GLYPH_ROWS * GLYPH_COLS;
  localparam int GAP_COLS   = 1;
  localparam int BLANK_COLS = 3;
  localparam int SCALE_W    = 5;
  localparam int SCALE_MAX  = 16;
  localparam int CODE_W     = 8;
  localparam int START_W    = 12;
  localparam int OUT_W      = 16;
  localparam int WIDTH_W    = 3;

  typedef struct packed {
    logic               hit;
    logic [WIDTH_W-1:0] width;
    logic [CELLS-1:0]   bits;   // row-major, top row and left column at the msb
  } glyph_t;

  // start command from the pen logic to the cell scanner
  typedef struct packed {
    logic             go;
    logic [CELLS-1:0] bits;
  } scan_ctl_t;

  typedef struct packed {
    logic             dot_valid;
    logic [OUT_W-1:0] dot_x;
    logic [OUT_W-1:0] dot_y;
    logic [OUT_W-1:0] next_pen_x;
    logic             last;
  } out_item_t;

  function automatic glyph_t mk_glyph(input logic [WIDTH_W-1:0] w,
                                      input logic [4:0] r0, input logic [4:0] r1,
                                      input logic [4:0] r2, input logic [4:0] r3,
                                      input logic [4:0] r4);
    glyph_t g;
    g.hit   = 1'b1;
    g.width = w;
    g.bits  = {r0, r1, r2, r3, r4};
    return g;
  endfunction

  function automatic glyph_t glyph_lookup(input logic [CODE_W-1:0] code);
    glyph_t g;
    g.hit   = 1'b0;
    g.width = WIDTH_W'(BLANK_COLS);
    g.bits  = '0;
    case (code)
      8'h30: g = mk_glyph(3'd3, 5'h1C, 5'h14, 5'h14, 5'h14, 5'h1C); // 0
      8'h31: g = mk_glyph(3'd3, 5'h08, 5'h18, 5'h08, 5'h08, 5'h1C); // 1
      8'h32: g = mk_glyph(3'd3, 5'h1C, 5'h04, 5'h1C, 5'h10, 5'h1C); // 2
      8'h33: g = mk_glyph(3'd3, 5'h1C, 5'h04, 5'h1C, 5'h04, 5'h1C); // 3
      8'h34: g = mk_glyph(3'd3, 5'h14, 5'h14, 5'h1C, 5'h04, 5'h04); // 4
      8'h35: g = mk_glyph(3'd3, 5'h1C, 5'h10, 5'h1C, 5'h04, 5'h1C); // 5
      8'h36: g = mk_glyph(3'd3, 5'h1C, 5'h10, 5'h1C, 5'h14, 5'h1C); // 6
      8'h37: g = mk_glyph(3'd3, 5'h1C, 5'h04, 5'h04, 5'h04, 5'h04); // 7
      8'h38: g = mk_glyph(3'd3, 5'h1C, 5'h14, 5'h1C, 5'h14, 5'h1C); // 8
      8'h39: g = mk_glyph(3'd3, 5'h1C, 5'h14, 5'h1C, 5'h04, 5'h1C); // 9
      8'h41: g = mk_glyph(3'd3, 5'h08, 5'h14, 5'h1C, 5'h14, 5'h14); // A
      8'h42: g = mk_glyph(3'd3, 5'h18, 5'h14, 5'h18, 5'h14, 5'h18); // B
      8'h43: g = mk_glyph(3'd3, 5'h1C, 5'h10, 5'h10, 5'h10, 5'h1C); // C
      8'h44: g = mk_glyph(3'd3, 5'h18, 5'h14, 5'h14, 5'h14, 5'h18); // D
      8'h45: g = mk_glyph(3'd3, 5'h1C, 5'h10, 5'h18, 5'h10, 5'h1C); // E
      8'h46: g = mk_glyph(3'd3, 5'h1C, 5'h10, 5'h18, 5'h10, 5'h10); // F
      8'h47: g = mk_glyph(3'd3, 5'h1C, 5'h10, 5'h14, 5'h14, 5'h1C); // G
      8'h48: g = mk_glyph(3'd3, 5'h14, 5'h14, 5'h1C, 5'h14, 5'h14); // H
      8'h49: g = mk_glyph(3'd3, 5'h1C, 5'h08, 5'h08, 5'h08, 5'h1C); // I
      8'h4A: g = mk_glyph(3'd3, 5'h04, 5'h04, 5'h04, 5'h14, 5'h1C); // J
      8'h4B: g = mk_glyph(3'd3, 5'h14, 5'h14, 5'h18, 5'h14, 5'h14); // K
      8'h4C: g = mk_glyph(3'd3, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1C); // L
      8'h4D: g = mk_glyph(3'd5, 5'h11, 5'h1B, 5'h15, 5'h11, 5'h11); // M
      8'h4E: g = mk_glyph(3'd4, 5'h12, 5'h1A, 5'h16, 5'h12, 5'h12); // N
      8'h4F: g = mk_glyph(3'd3, 5'h1C, 5'h14, 5'h14, 5'h14, 5'h1C); // O
      8'h50: g = mk_glyph(3'd3, 5'h1C, 5'h14, 5'h1C, 5'h10, 5'h10); // P
      8'h51: g = mk_glyph(3'd3, 5'h1C, 5'h14, 5'h14, 5'h1C, 5'h04); // Q
      8'h52: g = mk_glyph(3'd3, 5'h18, 5'h14, 5'h18, 5'h14, 5'h14); // R
      8'h53: g = mk_glyph(3'd3, 5'h1C, 5'h10, 5'h1C, 5'h04, 5'h1C); // S
      8'h54: g = mk_glyph(3'd3, 5'h1C, 5'h08, 5'h08, 5'h08, 5'h08); // T
      8'h55: g = mk_glyph(3'd3, 5'h14, 5'h14, 5'h14, 5'h14, 5'h1C); // U
      8'h56: g = mk_glyph(3'd3, 5'h14, 5'h14, 5'h14, 5'h14, 5'h08); // V
      8'h57: g = mk_glyph(3'd5, 5'h11, 5'h11, 5'h15, 5'h1B, 5'h11); // W
      8'h58: g = mk_glyph(3'd3, 5'h14, 5'h14, 5'h08, 5'h14, 5'h14); // X
      8'h59: g = mk_glyph(3'd3, 5'h14, 5'h14, 5'h08, 5'h08, 5'h08); // Y
      8'h5A: g = mk_glyph(3'd3, 5'h1C, 5'h04, 5'h08, 5'h10, 5'h1C); // Z
      8'h3A: g = mk_glyph(3'd3, 5'h00, 5'h08, 5'h00, 5'h08, 5'h00); // colon
      8'h2E: g = mk_glyph(3'd3, 5'h00, 5'h00, 5'h00, 5'h00, 5'h08); // period
      8'h25: g = mk_glyph(3'd3, 5'h14, 5'h04, 5'h08, 5'h10, 5'h14); // percent
      8'h2D: g = mk_glyph(3'd3, 5'h00, 5'h00, 5'h1C, 5'h00, 5'h00); // minus
      8'h28: g = mk_glyph(3'd2, 5'h08, 5'h10, 5'h10, 5'h10, 5'h08); // open paren
      8'h29: g = mk_glyph(3'd2, 5'h10, 5'h08, 5'h08, 5'h08, 5'h10); // close paren
      default: g.hit = 1'b0;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bfdg_if.sv =====
// bfdg_in_if / bfdg_out_if: valid-ready channels for characters and dot items
// depends on bfdg_pkg for field widths
`default_nettype none

interface bfdg_in_if import bfdg_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  char_code;
  logic               string_start;
  logic [START_W-1:0] start_x;
  logic [START_W-1:0] start_y;

  modport source (output valid, output char_code, output string_start,
                  output start_x, output start_y, input ready);
  modport sink   (input valid, input char_code, input string_start,
                  input start_x, input start_y, output ready);
endinterface

interface bfdg_out_if import bfdg_pkg::*;;
  logic             valid;
  logic             ready;
  logic             dot_valid;
  logic [OUT_W-1:0] dot_x;
  logic [OUT_W-1:0] dot_y;
  logic [OUT_W-1:0] next_pen_x;
  logic             last;

  modport source (output valid, output dot_valid, output dot_x, output dot_y,
                  output next_pen_x, output last, input ready);
  modport sink   (input valid, input dot_valid, input dot_x, input dot_y,
                  input next_pen_x, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/bfdg_cell_scan.sv =====
// bfdg_cell_scan: shifts bitmap out one cell per unstalled cycle, tracks dot coordinates
// depends on bfdg_pkg
`default_nettype none

module bfdg_cell_scan import bfdg_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  scan_ctl_t             ctl,
  input  wire  [COORD_BITS-1:0] base_x,
  input  wire  [COORD_BITS-1:0] base_y,
  input  wire  [COORD_BITS-1:0] next_x,
  input  wire  [SCALE_W-1:0]    scale,
  input  wire                   slot_free,
  output logic                  idle,
  output logic                  push,
  output out_item_t             item
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_CLOSE = 3'b100
  } scan_state_t;

  scan_state_t            state_r, state_nxt;
  logic [CELLS-1:0]       bits_r, bits_nxt, bits_shift;
  logic [WIDTH_W-1:0]     col_r, col_nxt;
  logic [COORD_BITS-1:0]  acc_x_r, acc_x_nxt;
  logic [COORD_BITS-1:0]  acc_y_r, acc_y_nxt;
  logic [COORD_BITS-1:0]  base_x_r, base_x_nxt;
  logic [COORD_BITS-1:0]  next_x_r, next_x_nxt;

  function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                    input logic [SCALE_W-1:0] b);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + (COORD_BITS+1)'(b);
    return s[COORD_BITS] ? '1 : s[COORD_BITS-1:0];
  endfunction

  assign idle       = (state_r == ST_IDLE);
  assign bits_shift = {bits_r[CELLS-2:0], 1'b0};

  always_comb begin
    state_nxt  = state_r;
    bits_nxt   = bits_r;
    col_nxt    = col_r;
    acc_x_nxt  = acc_x_r;
    acc_y_nxt  = acc_y_r;
    base_x_nxt = base_x_r;
    next_x_nxt = next_x_r;
    push       = 1'b0;
    item       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (ctl.go) begin
          bits_nxt   = ctl.bits;
          col_nxt    = '0;
          acc_x_nxt  = base_x;
          acc_y_nxt  = base_y;
          base_x_nxt = base_x;
          next_x_nxt = next_x;
          state_nxt  = (ctl.bits == '0) ? ST_CLOSE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        item.dot_valid  = 1'b1;
        item.dot_x      = OUT_W'(acc_x_r);
        item.dot_y      = OUT_W'(acc_y_r);
        item.next_pen_x = OUT_W'(next_x_r);
        if (slot_free) begin
          push     = bits_r[CELLS-1];
          bits_nxt = bits_shift;
          if (col_r == WIDTH_W'(GLYPH_COLS - 1)) begin
            col_nxt   = '0;
            acc_x_nxt = base_x_r;
            acc_y_nxt = sat_add(acc_y_r, scale);
          end else begin
            col_nxt   = col_r + 1'b1;
            acc_x_nxt = sat_add(acc_x_r, scale);
          end
          // nothing lit further on: go straight to the closing item
          if (bits_shift == '0) begin
            state_nxt = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        item.last       = 1'b1;
        item.next_pen_x = OUT_W'(next_x_r);
        if (slot_free) begin
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r   <= bits_nxt;
    col_r    <= col_nxt;
    acc_x_r  <= acc_x_nxt;
    acc_y_r  <= acc_y_nxt;
    base_x_r <= base_x_nxt;
    next_x_r <= next_x_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfdg_out_stage.sv =====
// bfdg_out_stage: output register that holds one dot item until the sink takes it
// depends on bfdg_pkg and bfdg_out_if
`default_nettype none

module bfdg_out_stage import bfdg_pkg::*; (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  out_item_t        item,
  output logic             slot_free,
  bfdg_out_if.source       out_chan
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign slot_free = !valid_r || out_chan.ready;
  assign valid_nxt = push || (valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && slot_free) begin
      item_r <= item;
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.dot_valid  = item_r.dot_valid;
  assign out_chan.dot_x      = item_r.dot_x;
  assign out_chan.dot_y      = item_r.dot_y;
  assign out_chan.next_pen_x = item_r.next_pen_x;
  assign out_chan.last       = item_r.last;

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_font_text_dot_generator.sv =====
// Bitmap font text dot generator: takes one character code per item and returns one item per
// lit dot of its 5x5 glyph cell, top row first, then a closing item with the advanced pen x.
// An item is accepted while the cell scanner is idle; the scanner then shifts the bitmap out
// one cell per cycle while the output slot is free, up to the last lit cell (at most 25), and
// then emits the closing item; a character without a glyph gives only the closing item. The
// sink may stall any item by holding ready low. Coordinates saturate at 2^COORD_BITS - 1 and the output
// fields carry the low 16 bits. dot_scale is clamped to 1..16 when written.
// depends on bfdg_pkg, bfdg_if, bfdg_cell_scan, bfdg_out_stage
`default_nettype none

module bitmap_font_text_dot_generator import bfdg_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [SCALE_W-1:0] cfg_wdata,
  bfdg_in_if.sink            in_chan,
  bfdg_out_if.source         out_chan
);

  logic [SCALE_W-1:0]    scale_r, scale_nxt;
  logic [COORD_BITS-1:0] pen_x_r, pen_y_r;
  logic [COORD_BITS-1:0] base_x, base_y, next_x;
  logic [COORD_BITS:0]   adv_sum;
  logic [7:0]            advance;
  logic                  accept, scan_idle, slot_free, push;
  glyph_t                glyph;
  scan_ctl_t             ctl;
  out_item_t             item;

  always_comb begin
    scale_nxt = cfg_wdata;
    if (cfg_wdata == '0) begin
      scale_nxt = SCALE_W'(1);
    end else if (cfg_wdata > SCALE_W'(SCALE_MAX)) begin
      scale_nxt = SCALE_W'(SCALE_MAX);
    end
  end

  assign in_chan.ready = scan_idle;
  assign accept        = in_chan.valid && scan_idle;

  assign glyph   = glyph_lookup(in_chan.char_code);
  assign base_x  = in_chan.string_start ? COORD_BITS'(in_chan.start_x) : pen_x_r;
  assign base_y  = in_chan.string_start ? COORD_BITS'(in_chan.start_y) : pen_y_r;
  assign advance = 8'(glyph.width + WIDTH_W'(GAP_COLS)) * 8'(scale_r);
  assign adv_sum = {1'b0, base_x} + (COORD_BITS+1)'(advance);
  assign next_x  = adv_sum[COORD_BITS] ? '1 : adv_sum[COORD_BITS-1:0];

  assign ctl = {accept, (glyph.hit ? glyph.bits : CELLS'(0))};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_W'(1);
      pen_x_r <= '0;
      pen_y_r <= '0;
    end else begin
      if (cfg_we) begin
        scale_r <= scale_nxt;
      end
      if (accept) begin
        pen_x_r <= next_x;
        pen_y_r <= base_y;
      end
    end
  end

  bfdg_cell_scan #(
    .COORD_BITS(COORD_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .base_x    (base_x),
    .base_y    (base_y),
    .next_x    (next_x),
    .scale     (scale_r),
    .slot_free (slot_free),
    .idle      (scan_idle),
    .push      (push),
    .item      (item)
  );

  bfdg_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .item      (item),
    .slot_free (slot_free),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bfdg_checker.sv =====
// bfdg_checker: port-level assertions for the text dot generator, bound to the top level
// depends on bfdg_pkg
`default_nettype none

module bfdg_checker import bfdg_pkg::*; (
  input wire             clk,
  input wire             rst_n,
  input wire             in_valid,
  input wire             in_ready,
  input wire             out_valid,
  input wire             out_ready,
  input wire             dot_valid,
  input wire [OUT_W-1:0] dot_x,
  input wire [OUT_W-1:0] dot_y,
  input wire [OUT_W-1:0] next_pen_x,
  input wire             last
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(dot_valid) && $stable(dot_x)
      && $stable(dot_y) && $stable(next_pen_x) && $stable(last))
    else $error("stalled output item changed");

  // one character at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a character is in flight");

  // dots and the closing item carry opposite dot_valid and last; the closing item has zero x and y
  a_last_xor_dot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (dot_valid != last) && (!last || (dot_x == '0 && dot_y == '0)))
    else $error("malformed dot or closing item");

  // every item of one run carries the same advanced pen x
  a_pen_same_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=> !out_valid || next_pen_x == $past(next_pen_x))
    else $error("next_pen_x changed inside a run");

endmodule

bind bitmap_font_text_dot_generator bfdg_checker u_bfdg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .dot_valid  (out_chan.dot_valid),
  .dot_x      (out_chan.dot_x),
  .dot_y      (out_chan.dot_y),
  .next_pen_x (out_chan.next_pen_x),
  .last       (out_chan.last)
);

`default_nettype wire

// ===== test/tb.sv =====
// tb: self-checking bench for bitmap_font_text_dot_generator, random valid/ready traffic both ways
// holds its own font table and pen model and checks every dot and closing item in order
// depends on bfdg_pkg, bfdg_if and the rtl of the block
`timescale 1ns / 1ps

module tb;
  import bfdg_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_STALL     = 400;
  localparam int MAX_REPORTS    = 40;
  localparam int COORD_MAX      = 65535;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic               start;
    logic [START_W-1:0] sx;
    logic [START_W-1:0] sy;
  } char_req_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [SCALE_W-1:0] cfg_wdata;

  bfdg_in_if  in_if ();
  bfdg_out_if out_if ();

  bitmap_font_text_dot_generator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  char_req_t    char_reqs[$];
  out_item_t    dots_due[$];
  int unsigned  pen_x = 0;
  int unsigned  pen_y = 0;
  logic [4:0]   dot_scale_q = 5'd1;
  int           errors = 0;
  int           sent = 0;
  bit           calm = 1'b0;
  int           stall_reqs = 0;
  int           stall_done = 0;
  int           stall_left = 0;
  int           idle_cycles = 0;
  string        font_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ:.%-()";

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // glyph table, rows top to bottom, leftmost column at bit 4 of each row
  function automatic bit font_glyph(input logic [7:0] code, output int unsigned cols,
                                    output logic [24:0] pat);
    cols = BLANK_COLS;
    pat = '0;
    font_glyph = 1'b1;
    case (code)
      "0": pat = {5'h1C, 5'h14, 5'h14, 5'h14, 5'h1C};
      "1": pat = {5'h08, 5'h18, 5'h08, 5'h08, 5'h1C};
      "2": pat = {5'h1C, 5'h04, 5'h1C, 5'h10, 5'h1C};
      "3": pat = {5'h1C, 5'h04, 5'h1C, 5'h04, 5'h1C};
      "4": pat = {5'h14, 5'h14, 5'h1C, 5'h04, 5'h04};
      "5": pat = {5'h1C, 5'h10, 5'h1C, 5'h04, 5'h1C};
      "6": pat = {5'h1C, 5'h10, 5'h1C, 5'h14, 5'h1C};
      "7": pat = {5'h1C, 5'h04, 5'h04, 5'h04, 5'h04};
      "8": pat = {5'h1C, 5'h14, 5'h1C, 5'h14, 5'h1C};
      "9": pat = {5'h1C, 5'h14, 5'h1C, 5'h04, 5'h1C};
      "A": pat = {5'h08, 5'h14, 5'h1C, 5'h14, 5'h14};
      "B": pat = {5'h18, 5'h14, 5'h18, 5'h14, 5'h18};
      "C": pat = {5'h1C, 5'h10, 5'h10, 5'h10, 5'h1C};
      "D": pat = {5'h18, 5'h14, 5'h14, 5'h14, 5'h18};
      "E": pat = {5'h1C, 5'h10, 5'h18, 5'h10, 5'h1C};
      "F": pat = {5'h1C, 5'h10, 5'h18, 5'h10, 5'h10};
      "G": pat = {5'h1C, 5'h10, 5'h14, 5'h14, 5'h1C};
      "H": pat = {5'h14, 5'h14, 5'h1C, 5'h14, 5'h14};
      "I": pat = {5'h1C, 5'h08, 5'h08, 5'h08, 5'h1C};
      "J": pat = {5'h04, 5'h04, 5'h04, 5'h14, 5'h1C};
      "K": pat = {5'h14, 5'h14, 5'h18, 5'h14, 5'h14};
      "L": pat = {5'h10, 5'h10, 5'h10, 5'h10, 5'h1C};
      "M": begin
        cols = 5;
        pat = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11};
      end
      "N": begin
        cols = 4;
        pat = {5'h12, 5'h1A, 5'h16, 5'h12, 5'h12};
      end
      "O": pat = {5'h1C, 5'h14, 5'h14, 5'h14, 5'h1C};
      "P": pat = {5'h1C, 5'h14, 5'h1C, 5'h10, 5'h10};
      "Q": pat = {5'h1C, 5'h14, 5'h14, 5'h1C, 5'h04};
      "R": pat = {5'h18, 5'h14, 5'h18, 5'h14, 5'h14};
      "S": pat = {5'h1C, 5'h10, 5'h1C, 5'h04, 5'h1C};
      "T": pat = {5'h1C, 5'h08, 5'h08, 5'h08, 5'h08};
      "U": pat = {5'h14, 5'h14, 5'h14, 5'h14, 5'h1C};
      "V": pat = {5'h14, 5'h14, 5'h14, 5'h14, 5'h08};
      "W": begin
        cols = 5;
        pat = {5'h11, 5'h11, 5'h15, 5'h1B, 5'h11};
      end
      "X": pat = {5'h14, 5'h14, 5'h08, 5'h14, 5'h14};
      "Y": pat = {5'h14, 5'h14, 5'h08, 5'h08, 5'h08};
      "Z": pat = {5'h1C, 5'h04, 5'h08, 5'h10, 5'h1C};
      ":": pat = {5'h00, 5'h08, 5'h00, 5'h08, 5'h00};
      ".": pat = {5'h00, 5'h00, 5'h00, 5'h00, 5'h08};
      "%": pat = {5'h14, 5'h04, 5'h08, 5'h10, 5'h14};
      "-": pat = {5'h00, 5'h00, 5'h1C, 5'h00, 5'h00};
      "(": begin
        cols = 2;
        pat = {5'h08, 5'h10, 5'h10, 5'h10, 5'h08};
      end
      ")": begin
        cols = 2;
        pat = {5'h10, 5'h08, 5'h08, 5'h08, 5'h10};
      end
      default: font_glyph = 1'b0;
    endcase
  endfunction

  function automatic int unsigned sat_coord(input int unsigned v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // expected dots of one character, then its closing item; moves the pen
  task automatic render_char(input char_req_t c);
    int unsigned sc;
    int unsigned cols;
    int unsigned adv_x;
    logic [24:0] pat;
    bit          hit;
    out_item_t   o;
    sc = (dot_scale_q == 0) ? 1 : ((dot_scale_q > SCALE_MAX) ? SCALE_MAX : dot_scale_q);
    if (c.start) begin
      pen_x = c.sx;
      pen_y = c.sy;
    end
    hit = font_glyph(c.code, cols, pat);
    adv_x = sat_coord(pen_x + (cols + GAP_COLS) * sc);
    if (hit) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        for (int cc = 0; cc < cols; cc++) begin
          if (pat[24 - 5 * r - cc]) begin
            o.dot_valid  = 1'b1;
            o.dot_x      = OUT_W'(sat_coord(pen_x + cc * sc));
            o.dot_y      = OUT_W'(sat_coord(pen_y + r * sc));
            o.next_pen_x = OUT_W'(adv_x);
            o.last       = 1'b0;
            dots_due.push_back(o);
          end
        end
      end
    end
    o.dot_valid  = 1'b0;
    o.dot_x      = '0;
    o.dot_y      = '0;
    o.next_pen_x = OUT_W'(adv_x);
    o.last       = 1'b1;
    dots_due.push_back(o);
    pen_x = adv_x;
  endtask

  function automatic void add_char(input logic [7:0] code, input logic st,
                                   input logic [11:0] x, input logic [11:0] y);
    char_req_t c;
    c.code  = code;
    c.start = st;
    c.sx    = x;
    c.sy    = y;
    char_reqs.push_back(c);
    sent++;
  endfunction

  function automatic logic [7:0] pick_code();
    if ($urandom_range(99) < 70) return font_chars[$urandom_range(font_chars.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [11:0] pick_coord();
    case ($urandom_range(7))
      0: return 12'd0;
      1: return 12'hFFF;
      default: return 12'($urandom_range(4095));
    endcase
  endfunction

  // one string: pen set on the first item, an occasional stray restart in the middle
  function automatic void add_string(input int len);
    add_char(pick_code(), 1'b1, pick_coord(), pick_coord());
    for (int k = 1; k < len; k++) begin
      add_char(pick_code(), ($urandom_range(19) == 0), pick_coord(), pick_coord());
    end
  endfunction

  task automatic drain();
    while (char_reqs.size() != 0 || in_if.valid || dots_due.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_scale(input logic [4:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    dot_scale_q = v;
  endtask

  // character driver
  always @(posedge clk) begin : drive_chars
    logic offer;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        render_char(char_reqs.pop_front());
      end
      // an offered item stays put until it is taken
      if (in_if.valid && !in_if.ready) offer = 1'b1;
      else offer = (char_reqs.size() != 0) && (calm || $urandom_range(99) >= 22);
      in_if.valid <= offer;
      if (offer) begin
        in_if.char_code    <= char_reqs[0].code;
        in_if.string_start <= char_reqs[0].start;
        in_if.start_x      <= char_reqs[0].sx;
        in_if.start_y      <= char_reqs[0].sy;
      end
    end
  end

  // dot monitor and receiver stalls
  always @(posedge clk) begin : watch_dots
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got.dot_valid  = out_if.dot_valid;
        got.dot_x      = out_if.dot_x;
        got.dot_y      = out_if.dot_y;
        got.next_pen_x = out_if.next_pen_x;
        got.last       = out_if.last;
        if (dots_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected dot item: valid=%0d x=%0d y=%0d next=%0d last=%0d",
                     $time, got.dot_valid, got.dot_x, got.dot_y, got.next_pen_x, got.last);
        end else begin
          want = dots_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"%0t: dot item mismatch: expected valid=%0d x=%0d y=%0d next=%0d ",
                        "last=%0d, got valid=%0d x=%0d y=%0d next=%0d last=%0d"},
                       $time, want.dot_valid, want.dot_x, want.dot_y, want.next_pen_x,
                       want.last, got.dot_valid, got.dot_x, got.dot_y, got.next_pen_x,
                       got.last);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        out_if.ready <= 1'b0;
      end else if (stall_reqs != stall_done) begin
        stall_done   <= stall_done + 1;
        stall_left   <= LONG_STALL;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 22);
      end
    end
  end

  // only accepted characters and expected items count as progress
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) ||
          (out_if.valid && out_if.ready && dots_due.size() != 0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("bitmap_font_text_dot_generator verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int s;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.char_code    = '0;
    in_if.string_start = 1'b0;
    in_if.start_x      = '0;
    in_if.start_y      = '0;
    out_if.ready       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // scale from reset: every glyph width, blanks, lower case, code extremes
    add_char("M", 1'b1, 12'd0, 12'd0);
    add_char("N", 1'b0, 12'd0, 12'd0);
    add_char("W", 1'b0, 12'd0, 12'd0);
    add_char("(", 1'b0, 12'd0, 12'd0);
    add_char(")", 1'b0, 12'd0, 12'd0);
    add_char(" ", 1'b0, 12'd0, 12'd0);
    add_char("a", 1'b0, 12'd0, 12'd0);
    add_char(8'h00, 1'b0, 12'd0, 12'd0);
    add_char(8'hFF, 1'b0, 12'hFFF, 12'hFFF);
    add_char(":", 1'b0, 12'd0, 12'd0);
    add_char(".", 1'b0, 12'd0, 12'd0);
    add_char("%", 1'b0, 12'd0, 12'd0);
    add_char("-", 1'b0, 12'd0, 12'd0);
    add_char("8", 1'b0, 12'd0, 12'd0);
    drain();
    // zero scale acts as one
    write_scale(5'd0);
    add_char("W", 1'b1, 12'hFFF, 12'hFFF);
    add_char("1", 1'b0, 12'd0, 12'd0);
    drain();
    // oversized scales clamp to the largest dot
    write_scale(5'd31);
    add_char("M", 1'b1, 12'hFFF, 12'd0);
    add_char("Q", 1'b0, 12'd0, 12'd0);
    drain();
    write_scale(5'd17);
    add_char("A", 1'b1, 12'd0, 12'hFFF);
    add_char("z", 1'b0, 12'd0, 12'd0);
    drain();
    write_scale(5'd16);
    add_char("#", 1'b0, 12'd0, 12'd0);
    add_char(")", 1'b0, 12'd0, 12'd0);
    drain();

    // random strings with scale changes, pauses, a long sink stall and a calm stretch
    s = 0;
    while (sent < 280) begin
      if (s > 0 && $urandom_range(3) == 0) begin
        drain();
        write_scale(5'($urandom_range(31)));
      end else if ($urandom_range(5) == 0) begin
        drain();
      end
      calm = (s >= 12 && s < 20);
      add_string((s == 3) ? 12 : $urandom_range(1, 10));
      if (s == 3) stall_reqs++;
      while (char_reqs.size() > 4) @(posedge clk);
      s++;
    end
    calm = 1'b0;
    drain();

    // long run of wide glyphs at the largest scale pushes the pen far to the right
    write_scale(5'd16);
    add_char("W", 1'b1, 12'hFFF, 12'hFFF);
    for (int k = 0; k < 120; k++) begin
      add_char(($urandom_range(1) != 0) ? 8'("M") : 8'("W"), 1'b0, pick_coord(), pick_coord());
    end
    for (int k = 0; k < 30; k++) begin
      add_char(pick_code(), 1'b0, pick_coord(), pick_coord());
    end
    drain();

    if (errors == 0) begin
      $display("bitmap_font_text_dot_generator verification clean");
    end else begin
      $display("bitmap_font_text_dot_generator verification failed");
    end
    $finish;
  end

endmodule
